[rtl/tcm_pkg.sv]
// Shared types and constants for the two-class thread/context matcher.
// Used by every module of the block but tcm_queue; depends on nothing else.
package tcm_pkg;

   localparam int TCM_THREADS   = 64;
   localparam int TCM_CONTEXTS  = 16;
   localparam int TCM_THREAD_W  = 6;
   localparam int TCM_CONTEXT_W = 4;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic                     user_class;
      logic [TCM_THREAD_W-1:0]  thread_id;
      logic [TCM_CONTEXT_W-1:0] context_id;
   } req_type;

   typedef struct packed {
      logic                     matched;
      logic [TCM_THREAD_W-1:0]  paired_thread;
      logic [TCM_CONTEXT_W-1:0] paired_context;
      logic                     dropped;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_req;
      logic pop;
      logic push;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic src_avail;
   } status_type;

endpackage

[rtl/two_class_thread_context_matcher.sv]
// Two-class FIFO matcher of threads and hardware contexts.
// A request is accepted in S_IDLE, the queues are accessed in S_DECIDE and the
// result is loaded in S_FINISH, which waits while an earlier result is not yet
// taken; the queue memory read is registered and used the cycle after the pop.
// Reset clears the controller and all queue pointers and counts; every queue
// starts empty and no clearing pass is needed.
module two_class_thread_context_matcher
   import tcm_pkg::*;
#(
   parameter int THREADS  = TCM_THREADS,
   parameter int CONTEXTS = TCM_CONTEXTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   tcm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tcm_datapath #(
      .THREADS (THREADS),
      .CONTEXTS(CONTEXTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .status     (status),
      .rsp_payload(rsp_payload)
   );

endmodule

[rtl/tcm_queue.sv]
// Circular FIFO with a one-port memory, head/tail pointers and a fill count.
// Depends on nothing; instantiated by tcm_datapath for each of the four queues.
module tcm_queue #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             pop,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign rd_data = rd_data_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop && !empty) begin
         head_in  = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (push && !full) begin
         tail_in  = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full && !pop) begin
         mem_ff[tail_ff] <= wr_data;
      end
      if (pop && !empty) begin
         rd_data_ff <= mem_ff[head_ff];
      end
   end

endmodule

[rtl/tcm_datapath.sv]
// Datapath: request register, the wait and idle queues of both classes,
// and result assembly. Depends on tcm_pkg and tcm_queue.
module tcm_datapath
   import tcm_pkg::*;
#(
   parameter int THREADS  = TCM_THREADS,
   parameter int CONTEXTS = TCM_CONTEXTS
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_payload
);

   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic    popped_ff;
   logic    dropped_ff, dropped_in;

   logic [1:0] wait_push, wait_pop, idle_push, idle_pop;
   logic [1:0] wait_empty, wait_full, idle_empty, idle_full;
   logic [TCM_THREAD_W-1:0]  wait_rd [2];
   logic [TCM_CONTEXT_W-1:0] idle_rd [2];

   logic is_release;
   logic cls;

   assign is_release = (req_ff.opcode == OP_RELEASE);
   assign cls        = req_ff.user_class;

   // A request pops the idle queue and falls back to the wait queue;
   // a release does the opposite.
   assign status.src_avail = is_release ? !wait_empty[cls] : !idle_empty[cls];

   always_comb begin
      wait_push = '0;
      wait_pop  = '0;
      idle_push = '0;
      idle_pop  = '0;
      if (is_release) begin
         wait_pop[cls]  = cmd.pop;
         idle_push[cls] = cmd.push;
      end else begin
         idle_pop[cls]  = cmd.pop;
         wait_push[cls] = cmd.push;
      end
      dropped_in = is_release ? idle_full[cls] : wait_full[cls];
   end

   for (genvar c = 0; c < 2; c++) begin : g_class
      tcm_queue #(
         .DEPTH(THREADS),
         .WIDTH(TCM_THREAD_W)
      ) u_wait (
         .clock  (clock),
         .reset  (reset),
         .push   (wait_push[c]),
         .pop    (wait_pop[c]),
         .wr_data(req_ff.thread_id),
         .rd_data(wait_rd[c]),
         .empty  (wait_empty[c]),
         .full   (wait_full[c])
      );

      tcm_queue #(
         .DEPTH(CONTEXTS),
         .WIDTH(TCM_CONTEXT_W)
      ) u_idle (
         .clock  (clock),
         .reset  (reset),
         .push   (idle_push[c]),
         .pop    (idle_pop[c]),
         .wr_data(req_ff.context_id),
         .rd_data(idle_rd[c]),
         .empty  (idle_empty[c]),
         .full   (idle_full[c])
      );
   end

   always_comb begin
      rsp_in = '0;
      if (popped_ff) begin
         rsp_in.matched = 1'b1;
         if (is_release) begin
            rsp_in.paired_thread  = wait_rd[cls];
            rsp_in.paired_context = req_ff.context_id;
         end else begin
            rsp_in.paired_thread  = req_ff.thread_id;
            rsp_in.paired_context = idle_rd[cls];
         end
      end else begin
         rsp_in.dropped = dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.pop) begin
         popped_ff  <= 1'b1;
         dropped_ff <= 1'b0;
      end else if (cmd.push) begin
         popped_ff  <= 1'b0;
         dropped_ff <= dropped_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[rtl/tcm_ctrl.sv]
// Controller state machine: sequences accept, queue access and result load.
// Depends on tcm_pkg.
module tcm_ctrl
   import tcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.pop  = status.src_avail;
            cmd.push = !status.src_avail;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.load_rsp = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
